>>> src/assert_macros.svh
// Assertion macros used by the RTL.
// Each macro checks at the rising clock edge and is disabled while reset is applied.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in the following cycle");

`endif

>>> src/acss_pkg.sv
package acss_pkg;

    localparam int MODE_W  = 3;
    localparam int HOURS_W = 5;
    localparam int MINS_W  = 6;
    localparam int SECS_W  = 6;
    localparam int STEP_W  = 6;
    localparam int BEEP_W  = 6;
    localparam int SEG_W   = 32;
    localparam int GREEN_W = 9;
    localparam int RED_W   = 20;

    localparam logic [BEEP_W-1:0] BEEP_SECONDS_RESET = 6'd7;

    localparam logic [7:0] GLYPH_O    = 8'h5c;
    localparam logic [7:0] GLYPH_N    = 8'h54;
    localparam logic [7:0] GLYPH_DASH = 8'h40;

    localparam logic [RED_W-1:0] RED_ALL_ON = 20'hfffff;

    typedef enum logic [MODE_W-1:0] {
        EV_TICK       = 3'd0,
        EV_FAST_PULSE = 3'd1,
        EV_FAST_STOP  = 3'd2,
        EV_DISP_TOG   = 3'd3,
        EV_ALARM_TOG  = 3'd4,
        EV_SET        = 3'd5
    } ev_code_t;

    // Seven-segment code of a decimal digit; anything above nine shows a nine.
    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] code;
        begin
            case (d)
                4'd0:    code = 8'h3f;
                4'd1:    code = 8'h06;
                4'd2:    code = 8'h5b;
                4'd3:    code = 8'h4f;
                4'd4:    code = 8'h66;
                4'd5:    code = 8'h6d;
                4'd6:    code = 8'h7d;
                4'd7:    code = 8'h07;
                4'd8:    code = 8'h7f;
                default: code = 8'h67;
            endcase
            return code;
        end
    endfunction

    // Tens digit of a value below sixty-four, found by comparisons.
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        begin
            if (v >= 6'd60)
                t = 4'd6;
            else if (v >= 6'd50)
                t = 4'd5;
            else if (v >= 6'd40)
                t = 4'd4;
            else if (v >= 6'd30)
                t = 4'd3;
            else if (v >= 6'd20)
                t = 4'd2;
            else if (v >= 6'd10)
                t = 4'd1;
            else
                t = 4'd0;
            return t;
        end
    endfunction

    // Two segment codes, tens then ones, of a value below sixty-four.
    function automatic logic [15:0] two_digits(input logic [5:0] v);
        logic [3:0] t;
        logic [5:0] ones;
        begin
            t    = tens_of(v);
            ones = v - {t[2:0], 3'b000} - {2'b00, t[2:0], 1'b0};
            return {seg_code(t), seg_code(ones[3:0])};
        end
    endfunction

    // Bar index: the step sum divided by thirteen, saturated at eight.
    function automatic logic [3:0] bar_index(input logic [STEP_W:0] sum);
        logic [3:0] idx;
        begin
            if (sum >= 7'd104)
                idx = 4'd8;
            else if (sum >= 7'd91)
                idx = 4'd7;
            else if (sum >= 7'd78)
                idx = 4'd6;
            else if (sum >= 7'd65)
                idx = 4'd5;
            else if (sum >= 7'd52)
                idx = 4'd4;
            else if (sum >= 7'd39)
                idx = 4'd3;
            else if (sum >= 7'd26)
                idx = 4'd2;
            else if (sum >= 7'd13)
                idx = 4'd1;
            else
                idx = 4'd0;
            return idx;
        end
    endfunction

endpackage

>>> src/acss_if.sv
interface acss_in_if;
    import acss_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [HOURS_W-1:0] set_hours;
    logic [MINS_W-1:0]  set_minutes;
    logic [SECS_W-1:0]  set_seconds;

    modport source (output valid, mode, set_hours, set_minutes, set_seconds, input ready);
    modport sink (input valid, mode, set_hours, set_minutes, set_seconds, output ready);
endinterface

interface acss_out_if;
    import acss_pkg::*;

    logic               valid;
    logic               ready;
    logic [SEG_W-1:0]   upper_segments;
    logic [SEG_W-1:0]   lower_segments;
    logic [GREEN_W-1:0] green_leds;
    logic [RED_W-1:0]   red_leds;
    logic               beeping;

    modport source (
        output valid, upper_segments, lower_segments, green_leds, red_leds, beeping,
        input ready
    );
    modport sink (
        input valid, upper_segments, lower_segments, green_leds, red_leds, beeping,
        output ready
    );
endinterface

>>> src/alarm_clock_seven_segment.sv
// An accepted event passes the input register and then the result register. One event
// transaction per cycle while the display side accepts; the state update is one pass of
// logic between the input register and the result register, so consecutive events chain.
// Reset (rst_n low, asynchronous): time and alarm at 00:00:00, steps at one, clock shown,
// alarm off, no beep, beep length seven ticks, both pipeline stages empty.
module alarm_clock_seven_segment (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [acss_pkg::BEEP_W-1:0] cfg_wr_data,
    acss_in_if.sink                     events,
    acss_out_if.source                  display
);
    import acss_pkg::*;

    // Configuration register: the length of a beep in ticks.
    logic [BEEP_W-1:0] beep_seconds_reg;

    // Input stage. It holds one event transaction until the logic below has used it.
    logic               s1_valid_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [HOURS_W-1:0] set_hours_reg;
    logic [MINS_W-1:0]  set_minutes_reg;
    logic [SECS_W-1:0]  set_seconds_reg;

    // Architectural state of the clock.
    logic [HOURS_W-1:0] clock_hours_reg, clock_hours_next;
    logic [MINS_W-1:0]  clock_minutes_reg, clock_minutes_next;
    logic [SECS_W-1:0]  clock_seconds_reg, clock_seconds_next;
    logic [HOURS_W-1:0] alarm_hours_reg, alarm_hours_next;
    logic [MINS_W-1:0]  alarm_minutes_reg, alarm_minutes_next;
    logic [SECS_W-1:0]  alarm_seconds_reg, alarm_seconds_next;
    logic [STEP_W-1:0]  second_step_reg, second_step_next;
    logic [STEP_W-1:0]  minute_step_reg, minute_step_next;
    logic               show_alarm_reg, show_alarm_next;
    logic               alarm_enabled_reg, alarm_enabled_next;
    logic [BEEP_W-1:0]  beep_left_reg, beep_left_next;
    logic               pulse_phase_reg, pulse_phase_next;

    // Result stage.
    logic               out_valid_reg;
    logic [SEG_W-1:0]   upper_segments_reg, upper_segments_next;
    logic [SEG_W-1:0]   lower_segments_reg, lower_segments_next;
    logic [GREEN_W-1:0] green_leds_reg, green_leds_next;
    logic [RED_W-1:0]   red_leds_reg, red_leds_next;
    logic               beeping_reg, beeping_next;

    // Working values of the update.
    ev_code_t           ev;
    logic               out_free;
    logic               advance;
    logic [STEP_W-1:0]  sec_step;
    logic [STEP_W-1:0]  min_step;
    logic [SECS_W:0]    sec_sum;
    logic [MINS_W:0]    min_sum;
    logic [HOURS_W-1:0] hr_sum;
    logic [HOURS_W-1:0] sat_hours;
    logic [MINS_W-1:0]  sat_minutes;
    logic [SECS_W-1:0]  sat_seconds;
    logic [BEEP_W-1:0]  beep_base;
    logic               do_check;
    logic [HOURS_W-1:0] disp_hours;
    logic [MINS_W-1:0]  disp_minutes;
    logic [SECS_W-1:0]  disp_seconds;
    logic [3:0]         bar_idx;

    // The result register is free when it is empty or its transaction leaves this cycle.
    // The input stage moves on whenever the result register is free. An empty input stage
    // still accepts an event while a finished display transaction waits downstream.
    assign out_free     = !out_valid_reg || display.ready;
    assign advance      = s1_valid_reg && out_free;
    assign events.ready = !s1_valid_reg || out_free;

    assign ev = ev_code_t'(mode_reg);

    // Saturation of the loaded time.
    assign sat_hours   = (set_hours_reg > 5'd23) ? 5'd23 : set_hours_reg;
    assign sat_minutes = (set_minutes_reg > 6'd59) ? 6'd59 : set_minutes_reg;
    assign sat_seconds = (set_seconds_reg > 6'd59) ? 6'd59 : set_seconds_reg;

    // Next state for the event in the input stage. A tick first counts the beep down,
    // then advances the time with the carry rules, then compares with the alarm. The
    // hours only ever step by one, so a roll past 23 clears the whole time.
    always_comb
    begin
        clock_hours_next   = clock_hours_reg;
        clock_minutes_next = clock_minutes_reg;
        clock_seconds_next = clock_seconds_reg;
        alarm_hours_next   = alarm_hours_reg;
        alarm_minutes_next = alarm_minutes_reg;
        alarm_seconds_next = alarm_seconds_reg;
        second_step_next   = second_step_reg;
        minute_step_next   = minute_step_reg;
        show_alarm_next    = show_alarm_reg;
        alarm_enabled_next = alarm_enabled_reg;
        pulse_phase_next   = pulse_phase_reg;
        beep_base          = beep_left_reg;
        do_check           = 1'b0;
        sec_step           = second_step_reg;
        min_step           = minute_step_reg;
        sec_sum            = '0;
        min_sum            = '0;
        hr_sum             = '0;

        case (ev)
            EV_TICK:
            begin
                if (beep_left_reg != '0)
                    beep_base = beep_left_reg - 6'd1;
                if (show_alarm_reg)
                begin
                    sec_step = 6'd1;
                    min_step = 6'd1;
                end
                second_step_next = sec_step;
                minute_step_next = min_step;

                sec_sum = {1'b0, clock_seconds_reg} + {1'b0, sec_step};
                min_sum = {1'b0, clock_minutes_reg};
                hr_sum  = clock_hours_reg;
                if (sec_sum >= 7'd60)
                begin
                    min_sum = {1'b0, clock_minutes_reg} + {1'b0, min_step};
                    sec_sum = '0;
                end
                if (min_sum >= 7'd60)
                begin
                    hr_sum  = clock_hours_reg + 5'd1;
                    min_sum = '0;
                end
                if (hr_sum >= 5'd24)
                begin
                    hr_sum  = '0;
                    min_sum = '0;
                    sec_sum = '0;
                end
                clock_hours_next   = hr_sum;
                clock_minutes_next = min_sum[MINS_W-1:0];
                clock_seconds_next = sec_sum[SECS_W-1:0];
                do_check           = 1'b1;
                pulse_phase_next   = !pulse_phase_reg;
            end
            EV_FAST_PULSE:
            begin
                if (second_step_reg <= 6'd60)
                    second_step_next = second_step_reg + 6'd1;
                else
                begin
                    second_step_next = 6'd60;
                    if (minute_step_reg >= 6'd59)
                        minute_step_next = 6'd60;
                    else
                        minute_step_next = minute_step_reg + 6'd1;
                end
            end
            EV_FAST_STOP:
            begin
                second_step_next = 6'd1;
                minute_step_next = 6'd1;
            end
            EV_DISP_TOG:
            begin
                show_alarm_next = !show_alarm_reg;
            end
            EV_ALARM_TOG:
            begin
                alarm_enabled_next = !alarm_enabled_reg;
            end
            EV_SET:
            begin
                if (show_alarm_reg)
                begin
                    alarm_hours_next   = sat_hours;
                    alarm_minutes_next = sat_minutes;
                    alarm_seconds_next = sat_seconds;
                end
                else
                begin
                    clock_hours_next   = sat_hours;
                    clock_minutes_next = sat_minutes;
                    clock_seconds_next = sat_seconds;
                end
                do_check = 1'b1;
            end
            default:
            begin
                do_check = 1'b0;
            end
        endcase

        // A match only starts a beep when none is running.
        if (do_check && alarm_enabled_reg && (beep_base == '0) &&
            (alarm_hours_next == clock_hours_next) &&
            (alarm_minutes_next == clock_minutes_next) &&
            (alarm_seconds_next == clock_seconds_next))
            beep_left_next = beep_seconds_reg;
        else
            beep_left_next = beep_base;
    end

    // Display from the state after the event. The red bar alone uses the pulse phase
    // from before the event.
    always_comb
    begin
        if (show_alarm_next)
        begin
            disp_hours   = alarm_hours_next;
            disp_minutes = alarm_minutes_next;
            disp_seconds = alarm_seconds_next;
        end
        else
        begin
            disp_hours   = clock_hours_next;
            disp_minutes = clock_minutes_next;
            disp_seconds = clock_seconds_next;
        end

        upper_segments_next[31:16] = alarm_enabled_next ? {GLYPH_O, GLYPH_N}
                                                        : {GLYPH_DASH, GLYPH_DASH};
        upper_segments_next[15:0]  = two_digits({1'b0, disp_hours});
        lower_segments_next        = {two_digits(disp_minutes), two_digits(disp_seconds)};

        bar_idx = bar_index({1'b0, second_step_next} + {1'b0, minute_step_next});
        for (int i = 0; i < GREEN_W; i++)
            green_leds_next[i] = (4'(i) <= bar_idx);

        beeping_next  = (beep_left_next != '0);
        red_leds_next = (beeping_next && pulse_phase_reg) ? RED_ALL_ON : '0;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beep_seconds_reg <= BEEP_SECONDS_RESET;
        else if (cfg_wr_en)
            beep_seconds_reg <= cfg_wr_data;
    end

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (events.ready)
            s1_valid_reg <= events.valid;
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            mode_reg        <= events.mode;
            set_hours_reg   <= events.set_hours;
            set_minutes_reg <= events.set_minutes;
            set_seconds_reg <= events.set_seconds;
        end
    end

    // Clock state, updated once for each event that moves into the result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hours_reg   <= '0;
            clock_minutes_reg <= '0;
            clock_seconds_reg <= '0;
            alarm_hours_reg   <= '0;
            alarm_minutes_reg <= '0;
            alarm_seconds_reg <= '0;
            second_step_reg   <= 6'd1;
            minute_step_reg   <= 6'd1;
            show_alarm_reg    <= 1'b0;
            alarm_enabled_reg <= 1'b0;
            beep_left_reg     <= '0;
            pulse_phase_reg   <= 1'b0;
        end
        else if (advance)
        begin
            clock_hours_reg   <= clock_hours_next;
            clock_minutes_reg <= clock_minutes_next;
            clock_seconds_reg <= clock_seconds_next;
            alarm_hours_reg   <= alarm_hours_next;
            alarm_minutes_reg <= alarm_minutes_next;
            alarm_seconds_reg <= alarm_seconds_next;
            second_step_reg   <= second_step_next;
            minute_step_reg   <= minute_step_next;
            show_alarm_reg    <= show_alarm_next;
            alarm_enabled_reg <= alarm_enabled_next;
            beep_left_reg     <= beep_left_next;
            pulse_phase_reg   <= pulse_phase_next;
        end
    end

    // Result stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            upper_segments_reg <= upper_segments_next;
            lower_segments_reg <= lower_segments_next;
            green_leds_reg     <= green_leds_next;
            red_leds_reg       <= red_leds_next;
            beeping_reg        <= beeping_next;
        end
    end

    assign display.valid          = out_valid_reg;
    assign display.upper_segments = upper_segments_reg;
    assign display.lower_segments = lower_segments_reg;
    assign display.green_leds     = green_leds_reg;
    assign display.red_leds       = red_leds_reg;
    assign display.beeping        = beeping_reg;

`include "assert_macros.svh"

    // The clock time never leaves its legal range.
    `ASSERT_SAME(a_clock_range, clk, rst_n, 1'b1, (clock_hours_reg <= 5'd23) && (clock_minutes_reg <= 6'd59) && (clock_seconds_reg <= 6'd59))
    // The second step stays between one and sixty-one, the minute step between one and sixty.
    `ASSERT_SAME(a_step_range, clk, rst_n, 1'b1, (second_step_reg >= 6'd1) && (second_step_reg <= 6'd61) && (minute_step_reg >= 6'd1) && (minute_step_reg <= 6'd60))
    // A beep with more than one tick left is never reloaded: it can only count down or hold.
    // On its last tick the count reaches zero, and a match on that same tick may start anew.
    `ASSERT_NEXT(a_no_retrigger, clk, rst_n, beep_left_reg > 6'd1, beep_left_reg <= $past(beep_left_reg))
    // The red bar in a delivered result is lit only while the beep runs.
    `ASSERT_SAME(a_red_needs_beep, clk, rst_n, out_valid_reg && (red_leds_reg != '0), beeping_reg)

endmodule

>>> dv/acss_sb_pkg.sv
`timescale 1ns / 100ps

package acss_sb_pkg;
    import acss_pkg::*;

    // Event codes with no action of their own; they only refresh the display.
    localparam logic [MODE_W-1:0] EV_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] EV_SPARE_7 = 3'd7;

    localparam bit [7:0] DIGIT_SEGS [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h67
    };

    typedef struct packed {
        logic [SEG_W-1:0]   upper;
        logic [SEG_W-1:0]   lower;
        logic [GREEN_W-1:0] green;
        logic [RED_W-1:0]   red;
        logic               beeping;
    } display_t;

    class display_scoreboard;
        bit [BEEP_W-1:0]  beep_length;
        bit [HOURS_W-1:0] clock_h, alarm_h;
        bit [MINS_W-1:0]  clock_m, alarm_m;
        bit [SECS_W-1:0]  clock_s, alarm_s;
        bit [STEP_W-1:0]  sec_step, min_step;
        bit               show_alarm, alarm_on, phase;
        bit [BEEP_W-1:0]  beep_left;
        display_t         expected_q[$];
        int unsigned      mismatches;

        function new();
            beep_length = BEEP_SECONDS_RESET;
            clock_h = '0; clock_m = '0; clock_s = '0;
            alarm_h = '0; alarm_m = '0; alarm_s = '0;
            sec_step = 1; min_step = 1;
            show_alarm = 0; alarm_on = 0; phase = 0;
            beep_left = '0;
            mismatches = 0;
        endfunction

        function void set_beep_length(bit [BEEP_W-1:0] v);
            beep_length = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void match_alarm();
            if (alarm_on && beep_left == 0 && alarm_h == clock_h &&
                alarm_m == clock_m && alarm_s == clock_s)
                beep_left = beep_length;
        endfunction

        function bit [7:0] digit_segs(int unsigned d);
            return DIGIT_SEGS[d > 9 ? 9 : d];
        endfunction

        // Applies one accepted event and queues the display it must produce.
        function void note_event(logic [MODE_W-1:0] mode, logic [HOURS_W-1:0] hrs,
                                 logic [MINS_W-1:0] mins, logic [SECS_W-1:0] secs);
            bit          phase_was;
            bit [6:0]    sum;
            int unsigned h, m, s, idx;
            display_t    exp;
            phase_was = phase;
            case (mode)
                EV_TICK:
                begin
                    if (beep_left != 0)
                        beep_left--;
                    if (show_alarm)
                    begin
                        sec_step = 1;
                        min_step = 1;
                    end
                    sum = {1'b0, clock_s} + {1'b0, sec_step};
                    clock_s = sum[5:0];
                    if (sum >= 60)
                    begin
                        sum = {1'b0, clock_m} + {1'b0, min_step};
                        clock_m = sum[5:0];
                        clock_s = '0;
                    end
                    else
                        sum = {1'b0, clock_m};
                    if (sum >= 60)
                    begin
                        clock_h++;
                        clock_m = '0;
                    end
                    if (clock_h >= 24)
                    begin
                        clock_h = '0;
                        clock_m = '0;
                        clock_s = '0;
                    end
                    match_alarm();
                    phase = !phase;
                end
                EV_FAST_PULSE:
                begin
                    if (sec_step <= 60)
                        sec_step++;
                    else
                    begin
                        sec_step = 60;
                        min_step++;
                        if (min_step >= 60)
                            min_step = 60;
                    end
                end
                EV_FAST_STOP:
                begin
                    sec_step = 1;
                    min_step = 1;
                end
                EV_DISP_TOG:
                    show_alarm = !show_alarm;
                EV_ALARM_TOG:
                    alarm_on = !alarm_on;
                EV_SET:
                begin
                    h = (hrs > 23) ? 23 : hrs;
                    m = (mins > 59) ? 59 : mins;
                    s = (secs > 59) ? 59 : secs;
                    if (show_alarm)
                    begin
                        alarm_h = HOURS_W'(h); alarm_m = MINS_W'(m); alarm_s = SECS_W'(s);
                    end
                    else
                    begin
                        clock_h = HOURS_W'(h); clock_m = MINS_W'(m); clock_s = SECS_W'(s);
                    end
                    match_alarm();
                end
                default:
                    ;
            endcase

            h = show_alarm ? 32'(alarm_h) : 32'(clock_h);
            m = show_alarm ? 32'(alarm_m) : 32'(clock_m);
            s = show_alarm ? 32'(alarm_s) : 32'(clock_s);
            exp.upper = alarm_on ? {GLYPH_O, GLYPH_N, 16'h0000} : {GLYPH_DASH, GLYPH_DASH, 16'h0000};
            exp.upper[15:0] = {digit_segs(h / 10), digit_segs(h % 10)};
            exp.lower = {digit_segs(m / 10), digit_segs(m % 10),
                         digit_segs(s / 10), digit_segs(s % 10)};
            idx = (sec_step + min_step) / 13;
            if (idx > 8)
                idx = 8;
            exp.green   = GREEN_W'((1 << (idx + 1)) - 1);
            exp.red     = (beep_left != 0 && phase_was) ? RED_ALL_ON : '0;
            exp.beeping = (beep_left != 0);
            expected_q.push_back(exp);
        endfunction

        function void check_display(display_t seen);
            display_t exp;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: display transaction with nothing expected: %h", $time, seen);
                return;
            end
            exp = expected_q.pop_front();
            if (seen.upper !== exp.upper || seen.lower !== exp.lower ||
                seen.green !== exp.green || seen.red !== exp.red ||
                seen.beeping !== exp.beeping)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: display mismatch: upper %h/%h lower %h/%h green %h/%h red %h/%h beep %b/%b (expected/actual)",
                             $time, exp.upper, seen.upper, exp.lower, seen.lower,
                             exp.green, seen.green, exp.red, seen.red,
                             exp.beeping, seen.beeping);
            end
        endfunction
    endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import acss_pkg::*;
    import acss_sb_pkg::*;

    // Clock, reset and the single configuration register port.
    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [BEEP_W-1:0] cfg_wr_data;

    acss_in_if  ev_if ();
    acss_out_if disp_if ();

    alarm_clock_seven_segment dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .events      (ev_if),
        .display     (disp_if)
    );

    display_scoreboard sb;

    // Percentages of cycles in which the event sender holds back and the display
    // receiver refuses a transaction. They are changed between phases.
    int unsigned gap_pct;
    int unsigned stall_pct;
    int unsigned events_sent;
    int unsigned beep_len;

    always #5 clk = ~clk;

    // The receiver decides its ready at the falling edge so that the value is stable
    // well before the rising edge at which the design samples it.
    always @(negedge clk)
        disp_if.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);

    // Every display transaction is checked at the rising edge on which it is accepted.
    always @(posedge clk)
    begin : display_monitor
        display_t seen;
        if (rst_n && disp_if.valid && disp_if.ready)
        begin
            seen.upper   = disp_if.upper_segments;
            seen.lower   = disp_if.lower_segments;
            seen.green   = disp_if.green_leds;
            seen.red     = disp_if.red_leds;
            seen.beeping = disp_if.beeping;
            sb.check_display(seen);
        end
    end

    // Offers one event transaction and returns at the falling edge after it has been
    // accepted. Valid is left high, so back-to-back events follow without a gap; the
    // next call or a drain lowers it.
    task automatic send_event(logic [MODE_W-1:0] mode, logic [HOURS_W-1:0] hrs,
                              logic [MINS_W-1:0] mins, logic [SECS_W-1:0] secs);
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            ev_if.valid <= 1'b0;
            @(negedge clk);
        end
        ev_if.valid       <= 1'b1;
        ev_if.mode        <= mode;
        ev_if.set_hours   <= hrs;
        ev_if.set_minutes <= mins;
        ev_if.set_seconds <= secs;
        @(posedge clk);
        while (!ev_if.ready)
            @(posedge clk);
        sb.note_event(mode, hrs, mins, secs);
        events_sent++;
        @(negedge clk);
    endtask

    // Events other than a set ignore the time fields, so they carry random junk there.
    task automatic send_plain(logic [MODE_W-1:0] mode);
        send_event(mode, HOURS_W'($urandom_range(0, 31)), MINS_W'($urandom_range(0, 63)),
                   SECS_W'($urandom_range(0, 63)));
    endtask

    // Holds the sender off until every display transaction has come back, then lets the
    // two pipeline stages settle.
    task automatic hold_until_drained();
        ev_if.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // The beep length is only ever changed with the block empty.
    task automatic write_beep_length(logic [BEEP_W-1:0] v);
        hold_until_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_beep_length(v);
        beep_len = 32'(v);
    endtask

    // A well-formed alarm sequence: load the clock, load an alarm a few seconds ahead,
    // arm it and tick through the match and (part of) the beep. A quarter of the runs
    // start just before midnight so that the alarm may lie past the roll-over.
    task automatic alarm_sequence();
        int unsigned h, m, s, lead, t, a, n_ticks;
        lead = $urandom_range(1, 6);
        if ($urandom_range(0, 3) == 0)
        begin
            h = 23;
            m = 59;
            s = $urandom_range(54, 59);
        end
        else
        begin
            h = $urandom_range(0, 23);
            m = $urandom_range(0, 59);
            s = $urandom_range(0, 59);
        end
        t = h * 3600 + m * 60 + s;
        a = (t + lead) % 86400;

        send_plain(EV_FAST_STOP);
        if (sb.show_alarm)
            send_plain(EV_DISP_TOG);
        send_event(EV_SET, HOURS_W'(h), MINS_W'(m), SECS_W'(s));
        send_plain(EV_DISP_TOG);
        send_event(EV_SET, HOURS_W'(a / 3600), MINS_W'((a / 60) % 60), SECS_W'(a % 60));
        send_plain(EV_DISP_TOG);
        // Now and then the alarm is left disarmed so that a silent match is seen too.
        if (sb.alarm_on == ($urandom_range(0, 7) == 0))
            send_plain(EV_ALARM_TOG);

        n_ticks = lead + $urandom_range(0, (beep_len > 20 ? 20 : beep_len) + 3);
        repeat (n_ticks)
        begin
            case ($urandom_range(0, 23))
                0: send_plain(EV_ALARM_TOG);
                1: send_plain(EV_DISP_TOG);
                2: send_event(EV_SET, HOURS_W'(h), MINS_W'(m), SECS_W'(s));
                default: ;
            endcase
            send_plain(EV_TICK);
        end
    endtask

    // Runs of fast-advance pulses; a third of them are long runs that can push both steps
    // into saturation and the green bar past the end of its table.
    task automatic fast_sequence();
        int unsigned n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(100, 130) : $urandom_range(1, 30);
        repeat (n)
        begin
            if ($urandom_range(0, 7) == 0)
                send_plain(EV_TICK);
            send_plain(EV_FAST_PULSE);
        end
        repeat ($urandom_range(1, 4))
            send_plain(EV_TICK);
        if ($urandom_range(0, 1) == 0)
            send_plain(EV_FAST_STOP);
    endtask

    // Activity with the alarm time on show: ticks force the steps back to one and sets
    // land in the alarm registers.
    task automatic alarm_view_sequence();
        if (!sb.show_alarm)
            send_plain(EV_DISP_TOG);
        repeat ($urandom_range(3, 10))
        begin
            case ($urandom_range(0, 5))
                0: send_event(EV_SET, HOURS_W'($urandom_range(0, 31)),
                              MINS_W'($urandom_range(0, 63)), SECS_W'($urandom_range(0, 63)));
                1: send_plain(EV_FAST_PULSE);
                default: send_plain(EV_TICK);
            endcase
        end
        if ($urandom_range(0, 1) == 0)
            send_plain(EV_DISP_TOG);
    endtask

    // Unstructured transactions over every code, the spare ones included.
    task automatic noise_sequence();
        repeat ($urandom_range(1, 8))
            send_event(MODE_W'($urandom_range(0, 7)), HOURS_W'($urandom_range(0, 31)),
                       MINS_W'($urandom_range(0, 63)), SECS_W'($urandom_range(0, 63)));
    endtask

    // Upper bound on the whole run; a correct run finishes in a small fraction of it.
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned beep_settings [8];
        int unsigned gap_settings [4];
        int unsigned stall_settings [4];
        int unsigned quota;
        int unsigned pick;

        beep_settings  = '{63, 0, 1, $urandom_range(2, 62), 7, 63, 2, $urandom_range(1, 63)};
        gap_settings   = '{0, 45, 0, 28};
        stall_settings = '{0, 0, 45, 28};

        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        ev_if.valid         = 1'b0;
        ev_if.mode          = EV_TICK;
        ev_if.set_hours     = '0;
        ev_if.set_minutes   = '0;
        ev_if.set_seconds   = '0;
        disp_if.ready       = 1'b0;
        gap_pct             = 0;
        stall_pct           = 0;
        events_sent         = 0;
        beep_len            = 32'(BEEP_SECONDS_RESET);
        sb                  = new();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed part, run with the reset beep length and no idling. It walks through
        // the midnight roll-over, set saturation, the alarm view forcing the steps, a
        // match with its beep, the absence of a retrigger, disarming during a beep and
        // the two spare codes.
        send_plain(EV_TICK);
        send_event(EV_SET, 5'd23, 6'd59, 6'd59);
        send_plain(EV_TICK);
        send_event(EV_SET, 5'd31, 6'd63, 6'd63);
        send_event(EV_SET, 5'd24, 6'd60, 6'd60);
        send_plain(EV_ALARM_TOG);
        send_plain(EV_DISP_TOG);
        send_event(EV_SET, 5'd0, 6'd0, 6'd2);
        send_plain(EV_TICK);
        send_plain(EV_DISP_TOG);
        send_plain(EV_TICK);
        send_plain(EV_TICK);
        send_plain(EV_TICK);
        send_event(EV_SET, 5'd0, 6'd0, 6'd2);
        send_plain(EV_ALARM_TOG);
        send_plain(EV_TICK);
        send_plain(EV_SPARE_6);
        send_plain(EV_SPARE_7);
        send_plain(EV_FAST_PULSE);
        send_plain(EV_FAST_PULSE);
        send_plain(EV_TICK);
        send_plain(EV_FAST_STOP);
        send_event(EV_SET, 5'd0, 6'd0, 6'd0);

        // Random part: eight phases, each with its own beep length and idling pattern.
        // The configuration write at the start of a phase also makes the sender wait
        // for every outstanding display transaction.
        for (int p = 0; p < 8; p++)
        begin
            write_beep_length(BEEP_W'(beep_settings[p]));
            gap_pct   = gap_settings[p % 4];
            stall_pct = stall_settings[p % 4];
            quota     = events_sent + 243;
            while (events_sent < quota)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    alarm_sequence();
                else if (pick < 65)
                    fast_sequence();
                else if (pick < 75)
                    alarm_view_sequence();
                else
                    noise_sequence();
                if ($urandom_range(0, 49) == 0)
                    hold_until_drained();
            end
        end

        // Let the last display transactions come back, then allow for the pipeline
        // depth so that any surplus transaction would still be caught.
        ev_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
